[hdl/assert_macros.svh]
// Assertion helpers for the checker in sose_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, masked while reset is high.
`define SOSE_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also holds across reset.
`define SOSE_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/sose_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sose_pkg
// Shared types and constants of the sum-of-sines height evaluator.
// ----------------------------------------------------------------------------
package sose_pkg;

  // Item kinds carried on the input tuser bit
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_WAVE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_NOW   = 2'd1;

  // 2^32 / (2 pi), Q0.32
  localparam logic [29:0] INV2PI = 30'd683565276;

  // Quarter-turn sine polynomial
  localparam logic [16:0] SIN_C1 = 17'd102944;
  localparam logic [15:0] SIN_C3 = 16'd42334;
  localparam logic [12:0] SIN_C5 = 13'd4926;
  localparam logic [16:0] Q16_ONE = 17'd65536;
  localparam logic [16:0] BLEND_HALF = 17'd32768;

  // amplitude * sine term
  localparam int unsigned TERM_W = 50;

  localparam int unsigned IN_TDATA_W  = 248;
  localparam int unsigned OUT_TDATA_W = 56;

  typedef struct packed {
    logic signed [31:0] amplitude;
    logic [30:0]        wavenumber;
    logic [30:0]        angular_speed;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic [18:0]        phase_offset;
  } wave_entry_t;

endpackage

[hdl/sose_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sose_lane
// One wave cell: its table entry and a ten-stage pipeline from a point to the
// amplitude-weighted sine term and the absolute amplitude.
// ----------------------------------------------------------------------------
module sose_lane (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                wr,
  input  logic                                active,
  input  sose_pkg::wave_entry_t               entry,
  input  logic signed [31:0]                  px,
  input  logic signed [31:0]                  py,
  input  logic signed [31:0]                  time_now,
  output logic signed [sose_pkg::TERM_W-1:0]  term,
  output logic [31:0]                         amp_abs
);

  // table entry, turn rates kept in turns (Q.32)
  logic signed [31:0] amp, dx, dy;
  logic [44:0]        kc, oc;
  logic [31:0]        pc;

  logic [60:0] kc_w, oc_w;
  logic [48:0] pc_w;

  assign kc_w = {30'd0, entry.wavenumber} * {31'd0, sose_pkg::INV2PI};
  assign oc_w = {30'd0, entry.angular_speed} * {31'd0, sose_pkg::INV2PI};
  assign pc_w = {30'd0, entry.phase_offset} * {19'd0, sose_pkg::INV2PI};

  always_ff @(posedge clk) begin
    if (rst) begin
      amp <= '0;
      dx  <= '0;
      dy  <= '0;
      kc  <= '0;
      oc  <= '0;
      pc  <= '0;
    end else if (wr) begin
      amp <= entry.amplitude;
      dx  <= entry.dir_x;
      dy  <= entry.dir_y;
      kc  <= kc_w[60:16];
      oc  <= oc_w[60:16];
      pc  <= pc_w[47:16];
    end
  end

  // P1: projections and time products (omega split 21 + 24 bits)
  logic signed [63:0] mx, my, mx_w, my_w;
  logic signed [56:0] tl, tl_w;
  logic signed [53:0] th_w;
  logic [23:0]        th;

  assign mx_w = dx * px;
  assign my_w = dy * py;
  assign tl_w = $signed({1'b0, oc[23:0]}) * time_now;
  assign th_w = $signed({1'b0, oc[44:24]}) * time_now;

  // P2
  logic signed [63:0] proj_w;
  logic signed [50:0] proj;
  logic [47:0]        tp_w;
  logic [31:0]        tp2;

  assign proj_w = (mx >>> 14) + (my >>> 14);
  assign tp_w   = tl[47:0] + {th, 24'd0};

  // P3: kc * proj in four partial products, only bits 63..32 are kept later
  logic [55:0]        mll_w, mll;
  logic [52:0]        mhl_w, mhl;
  logic signed [43:0] mlh_w;
  logic signed [40:0] mhh_w;
  logic [31:0]        mlh, tp3;
  logic [7:0]         mhh;

  assign mll_w = kc[23:0] * proj[31:0];
  assign mhl_w = kc[44:24] * proj[31:0];
  assign mlh_w = $signed({1'b0, kc[23:0]}) * $signed(proj[50:32]);
  assign mhh_w = $signed({1'b0, kc[44:24]}) * $signed(proj[50:32]);

  // P4
  logic [63:0] a1_w;
  logic [31:0] b1_w, a1h, b1, tp4;

  assign a1_w = {8'd0, mll} + {mhl[39:0], 24'd0};
  assign b1_w = mlh + {mhh, 24'd0};

  // P5: phase in turns
  logic [31:0] turn;

  // P6..P9: sine of the turn
  logic [15:0] f_w;
  logic [16:0] x_w;
  logic [33:0] xx_w;
  logic [16:0] x6, x7, x8, x2_6, x2_7;
  logic        neg6, neg7, neg8, neg9;
  logic [29:0] t1_w;
  logic [13:0] t1;
  logic [15:0] u_w;
  logic [32:0] t2_w;
  logic [16:0] t2;
  logic [16:0] v_w;
  logic [33:0] s0_w;
  logic [17:0] s0;

  assign f_w  = turn[29:14];
  assign x_w  = turn[30] ? (sose_pkg::Q16_ONE - {1'b0, f_w}) : {1'b0, f_w};
  assign xx_w = {17'd0, x_w} * {17'd0, x_w};
  assign t1_w = {13'd0, x2_6} * {17'd0, sose_pkg::SIN_C5};
  assign u_w  = sose_pkg::SIN_C3 - {2'd0, t1};
  assign t2_w = {16'd0, x2_7} * {17'd0, u_w};
  assign v_w  = sose_pkg::SIN_C1 - t2;
  assign s0_w = {17'd0, x8} * {17'd0, v_w};

  // P10: clamp, sign and weight
  logic [16:0]                        sm_w;
  logic signed [17:0]                 ss_w;
  logic signed [sose_pkg::TERM_W-1:0] prod_w;
  logic [31:0]                        abs_w;

  assign sm_w   = (s0 > {1'b0, sose_pkg::Q16_ONE}) ? sose_pkg::Q16_ONE : s0[16:0];
  assign ss_w   = neg9 ? -$signed({1'b0, sm_w}) : $signed({1'b0, sm_w});
  assign prod_w = amp * ss_w;
  assign abs_w  = amp[31] ? (~amp + 32'd1) : amp;

  always_ff @(posedge clk) begin
    if (en) begin
      mx   <= mx_w;
      my   <= my_w;
      tl   <= tl_w;
      th   <= th_w[23:0];
      proj <= proj_w[50:0];
      tp2  <= tp_w[47:16];
      mll  <= mll_w;
      mhl  <= mhl_w;
      mlh  <= mlh_w[31:0];
      mhh  <= mhh_w[7:0];
      tp3  <= tp2;
      a1h  <= a1_w[63:32];
      b1   <= b1_w;
      tp4  <= tp3;
      turn <= a1h + b1 - tp4 + pc;
      x6   <= x_w;
      x2_6 <= xx_w[32:16];
      neg6 <= turn[31];
      t1   <= t1_w[29:16];
      x7   <= x6;
      x2_7 <= x2_6;
      neg7 <= neg6;
      t2   <= t2_w[32:16];
      x8   <= x7;
      neg8 <= neg7;
      s0   <= s0_w[33:16];
      neg9 <= neg8;
      term    <= active ? prod_w : '0;
      amp_abs <= active ? abs_w : '0;
    end
  end

endmodule

[hdl/sum_of_sines_height_eval.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sum_of_sines_height_eval
// Water height as a sum of sines over a table of waves, with a blend factor.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries items: tuser selects a wave-table write or a point evaluation.
//   m_* returns height and blend for each evaluation; writes return nothing.
//   cfg_* writes wave_count (index 0) and time_now (index 1), taken at once.
//   Evaluations enter one per cycle while the output is not stalled. Each
//   wave has its own ten-stage cell, the cells feed a registered adder tree
//   of log2(MAX_WAVES) levels, two stages saturate and normalize, and an
//   18-stage restoring divider forms the blend. A table write is taken only
//   once no evaluation is in flight, so it waits behind earlier points.
//   Reset empties the pipeline, clears the table, sets wave_count to one and
//   time_now to zero.
//   When the receiver holds m_tready low with a result pending, the whole
//   pipeline freezes and s_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module sum_of_sines_height_eval #(
  parameter int MAX_WAVES = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // wave_index, amplitude, wavenumber, angular_speed, dir_x, dir_y,
  // phase_offset, point_x, point_y, zero fill
  input  logic [sose_pkg::IN_TDATA_W-1:0]     s_tdata,
  // op
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // height, blend, zero fill
  output logic [sose_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sose_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                         cfg_data
);

  localparam int LVL    = (MAX_WAVES > 1) ? $clog2(MAX_WAVES) : 1;
  localparam int LEAVES = 1 << LVL;
  localparam int SUM_W  = sose_pkg::TERM_W + LVL;
  localparam int TOT_W  = 32 + LVL;
  localparam int RW     = TOT_W + 18;
  localparam int QB     = 18;
  localparam int DEPTH  = 12 + LVL + QB;
  localparam logic [6:0] MAX_W7 = 7'(MAX_WAVES);

  // configuration
  logic [4:0]         wave_count;
  logic signed [31:0] time_now;
  logic [6:0]         wave_lim;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_count <= 5'd1;
      time_now   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        sose_pkg::CFG_WAVE_COUNT: wave_count <= cfg_data[4:0];
        sose_pkg::CFG_TIME_NOW:   time_now   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (wave_count == 5'd0) begin
      wave_lim = 7'd1;
    end else if ({2'd0, wave_count} > MAX_W7) begin
      wave_lim = MAX_W7;
    end else begin
      wave_lim = {2'd0, wave_count};
    end
  end

  // input fields
  sose_pkg::wave_entry_t entry;
  logic [3:0]            wave_index;
  logic signed [31:0]    point_x, point_y;

  assign wave_index          = s_tdata[3:0];
  assign entry.amplitude     = s_tdata[35:4];
  assign entry.wavenumber    = s_tdata[66:36];
  assign entry.angular_speed = s_tdata[97:67];
  assign entry.dir_x         = s_tdata[129:98];
  assign entry.dir_y         = s_tdata[161:130];
  assign entry.phase_offset  = s_tdata[180:162];
  assign point_x             = s_tdata[212:181];
  assign point_y             = s_tdata[244:213];

  // flow control
  logic             en, s_xfer, pipe_empty;
  logic [DEPTH-1:0] vpipe;

  assign en         = ~m_tvalid | m_tready;
  assign pipe_empty = ~|vpipe;
  assign s_tready   = en & ((s_tuser == sose_pkg::OP_EVAL) | pipe_empty);
  assign s_xfer     = s_tvalid & s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe    <= '0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      vpipe    <= {vpipe[DEPTH-2:0], s_xfer & (s_tuser == sose_pkg::OP_EVAL)};
      m_tvalid <= vpipe[DEPTH-1];
    end
  end

  // wave cells
  logic signed [sose_pkg::TERM_W-1:0] term [MAX_WAVES];
  logic [31:0]                        aabs [MAX_WAVES];

  for (genvar i = 0; i < MAX_WAVES; i++) begin : g_lane
    logic wr_i, act_i;
    assign wr_i  = s_xfer & (s_tuser == sose_pkg::OP_WRITE) & ({3'd0, wave_index} == 7'(i));
    assign act_i = 7'(i) < wave_lim;
    sose_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .wr       (wr_i),
      .active   (act_i),
      .entry    (entry),
      .px       (point_x),
      .py       (point_y),
      .time_now (time_now),
      .term     (term[i]),
      .amp_abs  (aabs[i])
    );
  end

  // registered adder tree, node k has children 2k and 2k+1
  logic signed [SUM_W-1:0] tsum [1:LEAVES-1];
  logic [TOT_W-1:0]        tabs [1:LEAVES-1];

  for (genvar k = 1; k < LEAVES; k++) begin : g_node
    logic signed [SUM_W-1:0] lc, rc;
    logic [TOT_W-1:0]        la, ra;
    if (2 * k >= LEAVES) begin : g_leaf
      if (2 * k - LEAVES < MAX_WAVES) begin : g_l
        assign lc = SUM_W'(term[2 * k - LEAVES]);
        assign la = TOT_W'(aabs[2 * k - LEAVES]);
      end else begin : g_lz
        assign lc = '0;
        assign la = '0;
      end
      if (2 * k + 1 - LEAVES < MAX_WAVES) begin : g_r
        assign rc = SUM_W'(term[2 * k + 1 - LEAVES]);
        assign ra = TOT_W'(aabs[2 * k + 1 - LEAVES]);
      end else begin : g_rz
        assign rc = '0;
        assign ra = '0;
      end
    end else begin : g_inner
      assign lc = tsum[2 * k];
      assign rc = tsum[2 * k + 1];
      assign la = tabs[2 * k];
      assign ra = tabs[2 * k + 1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        tsum[k] <= lc + rc;
        tabs[k] <= la + ra;
      end
    end
  end

  // saturate height
  logic [SUM_W-17:0] hf;
  logic              h_ovf;
  logic [31:0]       h1_h;
  logic [TOT_W-1:0]  h1_tot;

  assign hf    = tsum[1][SUM_W-1:16];
  assign h_ovf = ~(&hf[SUM_W-17:31] | ~|hf[SUM_W-17:31]);

  // normalize: blend = (h + total) * 2^15 / total
  logic signed [TOT_W:0] num_w;
  logic                  num_pos;
  logic [31:0]           h2_h;
  logic [TOT_W-1:0]      h2_tot;
  logic [RW-1:0]         h2_rem;
  logic                  h2_zero, h2_pos;

  assign num_w   = $signed({{(TOT_W - 31){h1_h[31]}}, h1_h}) + $signed({1'b0, h1_tot});
  assign num_pos = ~num_w[TOT_W] & (|num_w);

  always_ff @(posedge clk) begin
    if (en) begin
      h1_h    <= h_ovf ? (hf[SUM_W-17] ? 32'h8000_0000 : 32'h7fff_ffff) : hf[31:0];
      h1_tot  <= tabs[1];
      h2_h    <= h1_h;
      h2_tot  <= h1_tot;
      h2_zero <= (h1_tot == '0);
      h2_pos  <= num_pos;
      h2_rem  <= num_pos ? {3'd0, num_w[TOT_W-1:0], 15'd0} : '0;
    end
  end

  // restoring divider, one quotient bit per stage
  logic [RW-1:0]    drem [QB];
  logic [QB-1:0]    dq   [QB];
  logic [TOT_W-1:0] dtot [QB];
  logic [31:0]      dh   [QB];
  logic             dz   [QB];
  logic             dp   [QB];

  for (genvar j = 0; j < QB; j++) begin : g_div
    logic [RW-1:0]    rin, sh;
    logic [QB-1:0]    qin;
    logic [TOT_W-1:0] tin;
    logic [31:0]      hin;
    logic             zin, pin, ge;
    if (j == 0) begin : g_first
      assign rin = h2_rem;
      assign qin = '0;
      assign tin = h2_tot;
      assign hin = h2_h;
      assign zin = h2_zero;
      assign pin = h2_pos;
    end else begin : g_next
      assign rin = drem[j-1];
      assign qin = dq[j-1];
      assign tin = dtot[j-1];
      assign hin = dh[j-1];
      assign zin = dz[j-1];
      assign pin = dp[j-1];
    end
    assign sh = {18'd0, tin} << (QB - 1 - j);
    assign ge = (rin >= sh);
    always_ff @(posedge clk) begin
      if (en) begin
        drem[j] <= ge ? (rin - sh) : rin;
        dq[j]   <= {qin[QB-2:0], ge};
        dtot[j] <= tin;
        dh[j]   <= hin;
        dz[j]   <= zin;
        dp[j]   <= pin;
      end
    end
  end

  logic [16:0] blend_w;

  always_comb begin
    if (dz[QB-1]) begin
      blend_w = sose_pkg::BLEND_HALF;
    end else if (!dp[QB-1]) begin
      blend_w = '0;
    end else if (dq[QB-1] > {1'b0, sose_pkg::Q16_ONE}) begin
      blend_w = sose_pkg::Q16_ONE;
    end else begin
      blend_w = dq[QB-1][16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {7'd0, blend_w, dh[QB-1]};
    end
  end

endmodule

[hdl/sose_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sose_checker
// Port-level checks for the height evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sose_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [sose_pkg::OUT_TDATA_W-1:0] m_tdata
);

  // a held result keeps its payload
  `SOSE_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> $stable(m_tdata), "result changed while stalled")

  // a stalled output freezes intake
  `SOSE_ASSERT(a_in_block, clk, rst, m_tvalid && !m_tready |-> !s_tready, "input taken while output stalled")

  // blend never exceeds one
  `SOSE_ASSERT(a_blend_range, clk, rst, m_tvalid |-> m_tdata[48:32] <= 17'd65536, "blend above one")

  // reset empties the output
  `SOSE_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_tvalid, "result present after reset")

endmodule

bind sum_of_sines_height_eval sose_checker u_sose_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
